@@ design/bpc_pkg.sv @@
`default_nettype none
package bpc_pkg;
	localparam int NUM_FEATURES = 64;
	localparam int CELL_COUNT   = 16;
	localparam int CLASS_COUNT  = 8;
	localparam int MAX_EMIT     = 8;

	localparam int FEAT_W = $clog2(NUM_FEATURES);
	localparam int CELL_W = $clog2(CELL_COUNT);
	localparam int CLS_W  = $clog2(CLASS_COUNT);
	localparam int CELL_AW = FEAT_W + CELL_W + CLS_W;
	localparam int FC_AW   = FEAT_W + CLS_W;
	localparam int RNG_W   = 95;
	localparam int ACC_W   = 48;
	localparam int EMIT_CAP = (CLASS_COUNT < MAX_EMIT) ? CLASS_COUNT : MAX_EMIT;

	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
	localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;

	typedef enum logic [2:0] {
		FN_CELL     = 3'd0,
		FN_FALLBACK = 3'd1,
		FN_WEIGHT   = 3'd2,
		FN_BIAS     = 3'd3,
		FN_RANGE    = 3'd4,
		FN_SAMPLE   = 3'd5
	} func_t;

	typedef enum logic {
		REG_CELLS   = 1'b0,
		REG_CLASSES = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [30:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;
endpackage
`default_nettype wire

@@ design/bpc_ram.sv @@
`default_nettype none
module bpc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ design/bpc_div.sv @@
`default_nettype none
module bpc_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire bpc_pkg::div_req_t req,
	output bpc_pkg::div_rsp_t      rsp
);
	logic [31:0] quo_q;
	logic [30:0] rem_q;
	logic [30:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [31:0] trial;
	logic        ge;
	logic [31:0] diff;

	assign trial = {rem_q, quo_q[31]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[30:0] : trial[30:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
endmodule
`default_nettype wire

@@ design/binned_projection_classifier_top.sv @@
// channel  | handshake              | word
// config   | cfg_we (no wait)       | cfg_index, cfg_data
// command  | start & !busy          | func, feature, cell_req, class_id, value, range_high,
//          |                        | bin_width, last
// result   | out_valid, one cycle   | class_index, response, last_class
// Loads do not raise busy. A sample passes through a range check, the bin divider when in
// range, and the table reads and multiply-accumulate for each class; a last sample then
// emits one class result per cycle. After reset a clearing pass sweeps the tables
// with busy high. Results cannot be stalled.
`default_nettype none
module binned_projection_classifier_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  func,
	input  wire logic [5:0]  feature,
	input  wire logic [3:0]  cell_req,
	input  wire logic [2:0]  class_id,
	input  wire logic [31:0] value,
	input  wire logic [31:0] range_high,
	input  wire logic [30:0] bin_width,
	input  wire logic        last,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [4:0]  cfg_data,
	output logic             out_valid,
	output logic [2:0]       class_index,
	output logic [31:0]      response,
	output logic             last_class
);
	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_RANGE = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_MAC   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	localparam int CW = bpc_pkg::CLS_W;

	state_t state_q;
	logic [bpc_pkg::CELL_AW-1:0] clr_q;
	logic [4:0] cells_q;
	logic [3:0] classes_q;
	logic       inprog_q;
	logic [31:0] bias_q [bpc_pkg::CLASS_COUNT];
	logic signed [bpc_pkg::ACC_W-1:0] acc_q [bpc_pkg::CLASS_COUNT];

	logic [bpc_pkg::FEAT_W-1:0] feat_q;
	logic [31:0] val_q;
	logic        last_q;
	logic        use_cell_q;
	logic [bpc_pkg::CELL_W-1:0] idx_q;
	logic [CW:0] iss_q;
	logic        v_s1, v_s2;
	logic [CW-1:0] k_s1, k_s2;
	logic signed [63:0] prod_s2;
	logic [CW:0] em_q;

	logic accept, clearing;
	logic [bpc_pkg::RNG_W-1:0] rng_rd;
	logic [31:0] cell_rd, fb_rd, wt_rd;
	bpc_pkg::div_req_t dreq;
	bpc_pkg::div_rsp_t drsp;

	assign busy     = state_q != ST_IDLE;
	assign accept   = start && !busy;
	assign clearing = state_q == ST_CLEAR;

	logic sel_cell, sel_fb, sel_wt, sel_rng;
	assign sel_cell = accept && func == bpc_pkg::FN_CELL;
	assign sel_fb   = accept && func == bpc_pkg::FN_FALLBACK;
	assign sel_wt   = accept && func == bpc_pkg::FN_WEIGHT;
	assign sel_rng  = accept && func == bpc_pkg::FN_RANGE;

	logic [CW-1:0] iss_k;
	assign iss_k = iss_q[CW-1:0];

	bpc_ram #(.WIDTH(32), .DEPTH(1 << bpc_pkg::CELL_AW)) u_cell (
		.clk(clk), .we(clearing || sel_cell),
		.waddr(clearing ? clr_q : {feature, cell_req, class_id}),
		.wdata(clearing ? 32'd0 : value),
		.raddr({feat_q, idx_q, iss_k}), .rdata(cell_rd)
	);
	bpc_ram #(.WIDTH(32), .DEPTH(1 << bpc_pkg::FC_AW)) u_fb (
		.clk(clk), .we(clearing || sel_fb),
		.waddr(clearing ? clr_q[bpc_pkg::FC_AW-1:0] : {feature, class_id}),
		.wdata(clearing ? 32'd0 : value),
		.raddr({feat_q, iss_k}), .rdata(fb_rd)
	);
	bpc_ram #(.WIDTH(32), .DEPTH(1 << bpc_pkg::FC_AW)) u_wt (
		.clk(clk), .we(clearing || sel_wt),
		.waddr(clearing ? clr_q[bpc_pkg::FC_AW-1:0] : {feature, class_id}),
		.wdata(clearing ? bpc_pkg::ONE_Q16 : value),
		.raddr({feat_q, iss_k}), .rdata(wt_rd)
	);
	bpc_ram #(.WIDTH(bpc_pkg::RNG_W), .DEPTH(bpc_pkg::NUM_FEATURES)) u_rng (
		.clk(clk), .we(clearing || sel_rng),
		.waddr(clearing ? clr_q[bpc_pkg::FEAT_W-1:0] : feature),
		.wdata(clearing ? {bpc_pkg::S32_MAX, bpc_pkg::S32_MIN, 31'd0}
		                : {value, range_high, bin_width}),
		.raddr(feature), .rdata(rng_rd)
	);

	bpc_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic signed [31:0] lo, hi;
	logic [30:0] bw;
	logic in_rng;
	logic [32:0] dlt;
	assign lo  = rng_rd[94:63];
	assign hi  = rng_rd[62:31];
	assign bw  = rng_rd[30:0];
	assign in_rng = bw != '0 && $signed(val_q) >= lo && $signed(val_q) < hi;
	assign dlt = {val_q[31], val_q} - {lo[31], lo};

	assign dreq.start    = state_q == ST_RANGE && in_rng;
	assign dreq.dividend = dlt[31:0];
	assign dreq.divisor  = bw;

	logic [4:0] ncell_m1;
	logic [3:0] ncls;
	always_comb begin
		if (cells_q == 5'd0) begin
			ncell_m1 = 5'd0;
		end else if (cells_q > 5'(bpc_pkg::CELL_COUNT)) begin
			ncell_m1 = 5'(bpc_pkg::CELL_COUNT - 1);
		end else begin
			ncell_m1 = cells_q - 5'd1;
		end
		if (classes_q == 4'd0) begin
			ncls = 4'd1;
		end else if (classes_q > 4'(bpc_pkg::EMIT_CAP)) begin
			ncls = 4'(bpc_pkg::EMIT_CAP);
		end else begin
			ncls = classes_q;
		end
	end

	logic signed [31:0] resp_s1;
	logic signed [47:0] term;
	logic signed [48:0] sum;
	logic signed [bpc_pkg::ACC_W-1:0] acc_new;
	assign resp_s1 = use_cell_q ? cell_rd : fb_rd;
	assign term    = 48'(prod_s2 >>> 16);
	assign sum     = {acc_q[k_s2][47], acc_q[k_s2]} + {term[47], term};
	always_comb begin
		if (sum[48] != sum[47]) begin
			acc_new = sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		end else begin
			acc_new = sum[47:0];
		end
	end

	logic signed [bpc_pkg::ACC_W-1:0] acc_em;
	logic [31:0] sat_em;
	assign acc_em = acc_q[em_q[CW-1:0]];
	always_comb begin
		if (acc_em > 48'sh0000_7FFF_FFFF) begin
			sat_em = bpc_pkg::S32_MAX;
		end else if (acc_em < -48'sh0000_8000_0000) begin
			sat_em = bpc_pkg::S32_MIN;
		end else begin
			sat_em = acc_em[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			cells_q   <= 5'd16;
			classes_q <= 4'd8;
			inprog_q  <= 1'b0;
			iss_q     <= '0;
			em_q      <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
			for (int i = 0; i < bpc_pkg::CLASS_COUNT; i++) begin
				bias_q[i] <= '0;
				acc_q[i]  <= '0;
			end
		end else begin
			out_valid <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= v_s1;
			if (cfg_we) begin
				unique case (cfg_index)
					bpc_pkg::REG_CELLS:   cells_q   <= cfg_data;
					bpc_pkg::REG_CLASSES: classes_q <= cfg_data[3:0];
				endcase
			end
			if (v_s2) begin
				acc_q[k_s2] <= acc_new;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && func == bpc_pkg::FN_BIAS) begin
						bias_q[class_id] <= value;
					end
					if (accept && func == bpc_pkg::FN_SAMPLE) begin
						if (!inprog_q) begin
							for (int i = 0; i < bpc_pkg::CLASS_COUNT; i++) begin
								acc_q[i] <= 48'($signed(bias_q[i]));
							end
						end
						inprog_q <= 1'b1;
						state_q  <= ST_RANGE;
					end
				end
				ST_RANGE: begin
					iss_q <= '0;
					state_q <= in_rng ? ST_DIV : ST_MAC;
				end
				ST_DIV: begin
					if (drsp.done) begin
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (iss_q < (CW+1)'(bpc_pkg::CLASS_COUNT)) begin
						v_s1  <= 1'b1;
						iss_q <= iss_q + 1'b1;
					end else if (!v_s1 && !v_s2) begin
						em_q    <= '0;
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					out_valid <= 1'b1;
					em_q <= em_q + 1'b1;
					if (em_q == (CW+1)'(ncls - 4'd1)) begin
						inprog_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			feat_q <= feature;
			val_q  <= value;
			last_q <= last;
		end
		if (state_q == ST_RANGE) begin
			use_cell_q <= in_rng;
		end
		if (state_q == ST_DIV && drsp.done) begin
			idx_q <= (drsp.quotient > {27'd0, ncell_m1}) ? ncell_m1[bpc_pkg::CELL_W-1:0]
			                                             : drsp.quotient[bpc_pkg::CELL_W-1:0];
		end
		k_s1    <= iss_k;
		k_s2    <= k_s1;
		prod_s2 <= $signed(wt_rd) * resp_s1;
		if (state_q == ST_EMIT) begin
			class_index <= em_q[CW-1:0];
			response    <= sat_em;
			last_class  <= em_q == (CW+1)'(ncls - 4'd1);
		end
	end
endmodule
`default_nettype wire

@@ design/bpc_checker.sv @@
`default_nettype none
module bpc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic [2:0] func,
	input wire logic       out_valid,
	input wire logic [2:0] class_index,
	input wire logic       last_class
);
	a_end_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_class |=> !out_valid)
		else $error("word after final class");
	a_run_on: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_class |=> out_valid && class_index == $past(class_index) + 3'd1)
		else $error("class run broken");
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && class_index != 3'd0 |-> $past(out_valid))
		else $error("run not started at class zero");
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && func != bpc_pkg::FN_SAMPLE |=> !out_valid)
		else $error("word after load");
endmodule

bind binned_projection_classifier_top bpc_checker u_bpc_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
	.out_valid(out_valid), .class_index(class_index), .last_class(last_class)
);
`default_nettype wire

@@ bench/tb_binned_projection_classifier_top.sv @@
`timescale 1ns / 1ps
module tb_binned_projection_classifier_top;
	import bpc_pkg::*;

	localparam logic [2:0] FN_SPARE6 = 3'd6;
	localparam logic [2:0] FN_SPARE7 = 3'd7;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 80;

	typedef struct packed {
		logic [2:0]  fn;
		logic [5:0]  feat;
		logic [3:0]  cidx;
		logic [2:0]  cls;
		logic [31:0] val;
		logic [31:0] hi;
		logic [30:0] bw;
		logic        lst;
	} word_t;

	typedef struct packed {
		word_t       w;
		logic        fixed;
		logic [31:0] fixed_resp;
	} row_t;

	typedef struct packed {
		logic [2:0]  cls;
		logic [31:0] resp;
		logic        lastc;
	} score_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  func;
	logic [5:0]  feature;
	logic [3:0]  cell_req;
	logic [2:0]  class_id;
	logic [31:0] value;
	logic [31:0] range_high;
	logic [30:0] bin_width;
	logic        last;
	logic        cfg_we;
	logic        cfg_index;
	logic [4:0]  cfg_data;
	logic        out_valid;
	logic [2:0]  class_index;
	logic [31:0] response;
	logic        last_class;

	binned_projection_classifier_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.feature(feature), .cell_req(cell_req), .class_id(class_id), .value(value),
		.range_high(range_high), .bin_width(bin_width), .last(last), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .out_valid(out_valid),
		.class_index(class_index), .response(response), .last_class(last_class)
	);

	logic signed [31:0] cell_tab [NUM_FEATURES*CELL_COUNT*CLASS_COUNT];
	logic signed [31:0] fallback_tab [NUM_FEATURES*CLASS_COUNT];
	logic signed [31:0] weight_tab [NUM_FEATURES*CLASS_COUNT];
	logic signed [31:0] bias_tab [CLASS_COUNT];
	logic signed [31:0] low_tab [NUM_FEATURES];
	logic signed [31:0] high_tab [NUM_FEATURES];
	logic [30:0]        width_tab [NUM_FEATURES];
	longint             class_sum [CLASS_COUNT];
	bit                 run_open;
	logic [4:0]         cells_reg;
	logic [3:0]         classes_reg;

	score_t pending_scores [$];
	int errors;
	int cycles;
	int words_sent;
	int samples_sent;
	int scores_seen;
	int gap_max;

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_binned_projection_classifier_top: errors");
			$finish;
		end
	end

	function automatic longint clamp48(input longint x);
		if (x > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
		if (x < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
		return x;
	endfunction

	task automatic reset_model();
		for (int i = 0; i < NUM_FEATURES*CELL_COUNT*CLASS_COUNT; i++) cell_tab[i] = 0;
		for (int i = 0; i < NUM_FEATURES*CLASS_COUNT; i++) begin
			fallback_tab[i] = 0;
			weight_tab[i] = ONE_Q16;
		end
		for (int i = 0; i < CLASS_COUNT; i++) begin
			bias_tab[i] = 0;
			class_sum[i] = 0;
		end
		for (int i = 0; i < NUM_FEATURES; i++) begin
			low_tab[i] = S32_MAX;
			high_tab[i] = S32_MIN;
			width_tab[i] = '0;
		end
		run_open = 1'b0;
		cells_reg = 5'd16;
		classes_reg = 4'd8;
	endtask

	task automatic score_word(input word_t w, input logic fixed, input logic [31:0] fixed_resp);
		longint lo;
		longint hi;
		longint smp;
		longint bin;
		longint prod;
		longint a;
		int ncell;
		int nemit;
		int rbase;
		bit use_cell;
		score_t s;
		case (w.fn)
			FN_CELL: cell_tab[{w.feat, w.cidx, w.cls}] = w.val;
			FN_FALLBACK: fallback_tab[{w.feat, w.cls}] = w.val;
			FN_WEIGHT: weight_tab[{w.feat, w.cls}] = w.val;
			FN_BIAS: bias_tab[w.cls] = w.val;
			FN_RANGE: begin
				low_tab[w.feat] = w.val;
				high_tab[w.feat] = w.hi;
				width_tab[w.feat] = w.bw;
			end
			FN_SAMPLE: begin
				if (!run_open) begin
					for (int j = 0; j < CLASS_COUNT; j++) class_sum[j] = bias_tab[j];
					run_open = 1'b1;
				end
				lo = low_tab[w.feat];
				hi = high_tab[w.feat];
				smp = longint'(signed'(w.val));
				use_cell = (width_tab[w.feat] != 0) && smp >= lo && smp < hi;
				ncell = (cells_reg < 1) ? 1 : (cells_reg > CELL_COUNT) ? CELL_COUNT : cells_reg;
				bin = use_cell ? (smp - lo) / longint'(width_tab[w.feat]) : 0;
				if (bin > ncell - 1) bin = ncell - 1;
				rbase = (w.feat * CELL_COUNT + int'(bin)) * CLASS_COUNT;
				for (int j = 0; j < CLASS_COUNT; j++) begin
					prod = longint'(weight_tab[w.feat*CLASS_COUNT + j]) *
						longint'(use_cell ? cell_tab[rbase + j]
							: fallback_tab[w.feat*CLASS_COUNT + j]);
					class_sum[j] = clamp48(class_sum[j] + (prod >>> 16));
				end
				if (w.lst) begin
					nemit = (classes_reg < 1) ? 1 : (classes_reg > EMIT_CAP) ? EMIT_CAP
						: classes_reg;
					for (int j = 0; j < nemit; j++) begin
						a = class_sum[j];
						if (a > 64'sh7FFF_FFFF) a = 64'sh7FFF_FFFF;
						if (a < -64'sh8000_0000) a = -64'sh8000_0000;
						s.cls = j[2:0];
						s.resp = fixed ? fixed_resp : a[31:0];
						s.lastc = (j == nemit - 1);
						pending_scores = {pending_scores, s};
					end
					run_open = 1'b0;
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		score_t e;
		if (arst_n && out_valid) begin
			scores_seen++;
			if (pending_scores.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word: class %0d response %h", class_index, response);
			end else begin
				e = pending_scores.pop_front();
				if (e.cls !== class_index || e.resp !== response || e.lastc !== last_class) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp class %0d resp %h last %b, got %0d %h %b",
							e.cls, e.resp, e.lastc, class_index, response, last_class);
				end
			end
		end
	end

	task automatic send_word(input word_t w, input int gap, input logic fixed,
		input logic [31:0] fixed_resp);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		func = w.fn;
		feature = w.feat;
		cell_req = w.cidx;
		class_id = w.cls;
		value = w.val;
		range_high = w.hi;
		bin_width = w.bw;
		last = w.lst;
		start = 1'b1;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		score_word(w, fixed, fixed_resp);
		words_sent++;
		if (w.fn == FN_SAMPLE) samples_sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		start = 1'b0;
		while (pending_scores.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		@(negedge clk);
	endtask

	task automatic write_regs(input logic [4:0] cells, input logic [3:0] classes);
		wait_idle();
		cfg_we = 1'b1;
		cfg_index = REG_CELLS;
		cfg_data = cells;
		@(negedge clk);
		cfg_index = REG_CLASSES;
		cfg_data = {1'b0, classes};
		@(negedge clk);
		cfg_we = 1'b0;
		cells_reg = cells;
		classes_reg = classes;
	endtask

	function automatic word_t random_word();
		word_t w;
		int pick;
		w.feat = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 5));
		w.cidx = 4'($urandom);
		w.cls = 3'($urandom);
		w.val = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 32'h0018_0000))
			- 32'h0004_0000;
		w.hi = $urandom;
		w.bw = 31'($urandom);
		w.lst = ($urandom_range(0, 3) == 0);
		pick = $urandom_range(0, 99);
		if (pick < 45) w.fn = FN_SAMPLE;
		else if (pick < 62) w.fn = FN_CELL;
		else if (pick < 70) w.fn = FN_FALLBACK;
		else if (pick < 78) w.fn = FN_WEIGHT;
		else if (pick < 83) w.fn = FN_BIAS;
		else if (pick < 96) begin
			w.fn = FN_RANGE;
			if ($urandom_range(0, 3) != 0) begin
				w.val = 32'($urandom_range(0, 32'h0002_0000)) - 32'h0004_0000;
				w.bw = 31'($urandom_range(1, 32'h0003_0000));
				w.hi = w.val + 32'($urandom_range(1, 20)) * {1'b0, w.bw};
			end
		end else w.fn = pick[0] ? FN_SPARE6 : FN_SPARE7;
		return w;
	endfunction

	row_t plan [$] = '{
		'{'{FN_SAMPLE, 6'd0, 4'd0, 3'd0, 32'h0, 32'h0, 31'h0, 1'b1}, 1'b1, 32'h0},
		'{'{FN_BIAS, 6'd0, 4'd0, 3'd0, S32_MAX, 32'h0, 31'h0, 1'b0}, 1'b0, 32'h0},
		'{'{FN_FALLBACK, 6'd1, 4'd0, 3'd0, S32_MAX, 32'h0, 31'h0, 1'b1}, 1'b0, 32'h0},
		'{'{FN_WEIGHT, 6'd1, 4'd0, 3'd0, S32_MAX, 32'h0, 31'h0, 1'b0}, 1'b0, 32'h0},
		'{'{FN_SAMPLE, 6'd1, 4'd0, 3'd0, S32_MIN, 32'h0, 31'h0, 1'b0}, 1'b0, 32'h0},
		'{'{FN_SAMPLE, 6'd1, 4'd0, 3'd0, 32'h5, 32'h0, 31'h0, 1'b1}, 1'b1, S32_MAX},
		'{'{FN_WEIGHT, 6'd1, 4'd0, 3'd0, S32_MIN, 32'h0, 31'h0, 1'b0}, 1'b0, 32'h0},
		'{'{FN_BIAS, 6'd0, 4'd0, 3'd0, S32_MIN, 32'h0, 31'h0, 1'b0}, 1'b0, 32'h0},
		'{'{FN_SAMPLE, 6'd1, 4'd0, 3'd0, 32'h0, 32'h0, 31'h0, 1'b1}, 1'b1, S32_MIN},
		'{'{FN_RANGE, 6'd2, 4'd0, 3'd0, 32'h0, 32'h0010_0000, 31'h1_0000, 1'b0}, 1'b0, 32'h0},
		'{'{FN_CELL, 6'd2, 4'd3, 3'd0, 32'h0002_0000, 32'h0, 31'h0, 1'b0}, 1'b0, 32'h0},
		'{'{FN_CELL, 6'd2, 4'd15, 3'd0, 32'h0003_0000, 32'h0, 31'h0, 1'b0}, 1'b0, 32'h0},
		'{'{FN_BIAS, 6'd0, 4'd0, 3'd0, 32'h0, 32'h0, 31'h0, 1'b0}, 1'b0, 32'h0},
		'{'{FN_SAMPLE, 6'd2, 4'd0, 3'd0, 32'h0003_8000, 32'h0, 31'h0, 1'b0}, 1'b0, 32'h0},
		'{'{FN_SAMPLE, 6'd2, 4'd0, 3'd0, 32'h000F_0000, 32'h0, 31'h0, 1'b0}, 1'b0, 32'h0},
		'{'{FN_SAMPLE, 6'd2, 4'd0, 3'd0, 32'h0010_0000, 32'h0, 31'h0, 1'b0}, 1'b0, 32'h0},
		'{'{FN_SAMPLE, 6'd63, 4'd0, 3'd0, 32'h0, 32'h0, 31'h0, 1'b1}, 1'b0, 32'h0},
		'{'{FN_RANGE, 6'd3, 4'd0, 3'd0, S32_MIN, S32_MAX, 31'h0, 1'b0}, 1'b0, 32'h0},
		'{'{FN_SAMPLE, 6'd3, 4'd0, 3'd0, 32'h1234_5678, 32'h0, 31'h0, 1'b1}, 1'b0, 32'h0},
		'{'{FN_SPARE6, 6'd2, 4'd0, 3'd0, 32'h0, 32'h0, 31'h0, 1'b1}, 1'b0, 32'h0},
		'{'{FN_SPARE7, 6'd2, 4'd0, 3'd0, 32'h0, 32'h0, 31'h0, 1'b1}, 1'b0, 32'h0},
		'{'{FN_CELL, 6'd63, 4'd15, 3'd7, 32'hFFFF_FFFF, 32'h0, 31'h0, 1'b0}, 1'b0, 32'h0},
		'{'{FN_RANGE, 6'd63, 4'd0, 3'd0, S32_MIN, S32_MAX, 31'h7FFF_FFFF, 1'b0}, 1'b0, 32'h0},
		'{'{FN_SAMPLE, 6'd63, 4'd0, 3'd0, 32'h7FFF_FFFE, 32'h0, 31'h0, 1'b1}, 1'b0, 32'h0}
	};

	initial begin
		logic [4:0] cells_plan [6] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd16};
		logic [3:0] classes_plan [6] = '{4'd8, 4'd3, 4'd0, 4'd15, 4'd1, 4'd8};
		int gap;
		errors = 0;
		cycles = 0;
		words_sent = 0;
		samples_sent = 0;
		scores_seen = 0;
		arst_n = 1'b0;
		start = 1'b0;
		func = FN_CELL;
		feature = '0;
		cell_req = '0;
		class_id = '0;
		value = '0;
		range_high = '0;
		bin_width = '0;
		last = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CELLS;
		cfg_data = '0;
		reset_model();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		write_regs(5'd16, 4'd1);
		foreach (plan[i]) send_word(plan[i].w, (i % 3 == 0) ? 0 : $urandom_range(0, 15),
			plan[i].fixed, plan[i].fixed_resp);
		for (int ph = 0; ph < 6; ph++) begin
			write_regs(cells_plan[ph], classes_plan[ph]);
			gap_max = ph[0] ? 0 : 15;
			for (int n = 0; n < 16; n++) begin
				if (ph == 2 && n == 10) wait_idle();
				gap = $urandom_range(0, gap_max);
				send_word(random_word(), gap, 1'b0, 32'h0);
			end
		end
		wait_idle();
		$display("sent %0d words (%0d samples) over 6 register settings, checked %0d results",
			words_sent, samples_sent, scores_seen);
		if (errors == 0 && pending_scores.size() == 0)
			$display("tb_binned_projection_classifier_top: clean");
		else
			$display("tb_binned_projection_classifier_top: errors");
		$finish;
	end
endmodule
